[rtl/olid_pkg.sv]
`timescale 1ns / 1ps

package olid_pkg;

	// List geometry and field widths.
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ACT_W   = 2;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 7;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic check;
		logic init;
		logic rd;
		logic shift_wr;
		logic commit;
		logic load_res;
	} olid_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic             err;
		logic [ACT_W-1:0] action;
		logic             more;
	} olid_sts_t;

endpackage

[rtl/olid_if.sv]
`timescale 1ns / 1ps

interface olid_req_if;
	import olid_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;

	modport source(output valid, action, position, value, input ready);
	modport sink(input valid, action, position, value, output ready);
endinterface

interface olid_res_if;
	import olid_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [VAL_W-1:0]  read_value;
	logic [CNT_W-1:0]         count;

	modport source(output valid, status, read_value, count, input ready);
	modport sink(input valid, status, read_value, count, output ready);
endinterface

[rtl/olid_ram.sv]
`timescale 1ns / 1ps

module olid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/olid_dp.sv]
`timescale 1ns / 1ps

module olid_dp import olid_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  olid_cmd_t               cmd,
	output olid_sts_t               sts,
	input  logic [ACT_W-1:0]        in_action,
	input  logic [POS_W-1:0]        in_position,
	input  logic signed [VAL_W-1:0] in_value,
	output logic [STAT_W-1:0]       res_status,
	output logic signed [VAL_W-1:0] res_read_value,
	output logic [CNT_W-1:0]        res_count
);

	logic [ACT_W-1:0]  act_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [STAT_W-1:0] stat_q;
	logic [STAT_W-1:0] res_status_q;
	logic [VAL_W-1:0]  res_rdata_q;
	logic [CNT_W-1:0]  res_count_q;

	logic [POS_W-1:0]  pm1;
	logic              pos_zero;
	logic              full;
	logic              bad_ins;
	logic              bad_rd;
	logic [STAT_W-1:0] err_code;
	logic              more;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  commit_addr;

	assign pm1      = pos_q - POS_W'(1);
	assign pos_zero = (pos_q == '0);
	assign full     = (cnt_q >= CNT_W'(DEPTH));
	assign bad_ins  = pos_zero || ({1'b0, pos_q} > ({1'b0, cnt_q} + (CNT_W+1)'(1)));
	assign bad_rd   = pos_zero || ({1'b0, pos_q} > {1'b0, cnt_q});

	always_comb begin
		case (act_q)
			ACT_APPEND: err_code = full ? ST_FULL : ST_OK;
			ACT_INSERT: err_code = bad_ins ? ST_BADPOS : (full ? ST_FULL : ST_OK);
			ACT_DELETE: err_code = bad_rd ? ST_BADPOS : ST_OK;
			ACT_READ:   err_code = bad_rd ? ST_BADPOS : ST_OK;
			default:    err_code = ST_OK;
		endcase
	end

	// Insert walks down from the tail, delete walks up toward the tail.
	always_comb begin
		case (act_q)
			ACT_INSERT: more = (idx_q > CNT_W'(pm1));
			ACT_DELETE: more = (({1'b0, idx_q} + (CNT_W+1)'(1)) < {1'b0, cnt_q});
			default:    more = 1'b0;
		endcase
	end

	always_comb begin
		case (act_q)
			ACT_INSERT: ram_raddr = ADDR_W'(idx_q - CNT_W'(1));
			ACT_DELETE: ram_raddr = ADDR_W'(idx_q + CNT_W'(1));
			default:    ram_raddr = ADDR_W'(pm1);
		endcase
	end

	assign commit_addr = (act_q == ACT_APPEND) ? cnt_q : CNT_W'(pm1);
	assign ram_we    = cmd.shift_wr ||
		(cmd.commit && (act_q == ACT_APPEND || act_q == ACT_INSERT));
	assign ram_waddr = cmd.shift_wr ? ADDR_W'(idx_q) : ADDR_W'(commit_addr);
	assign ram_wdata = cmd.shift_wr ? ram_rdata : val_q;

	assign sts.err    = (err_code != ST_OK);
	assign sts.action = act_q;
	assign sts.more   = more;

	olid_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.commit) begin
			case (act_q)
				ACT_APPEND: cnt_q <= cnt_q + CNT_W'(1);
				ACT_INSERT: cnt_q <= cnt_q + CNT_W'(1);
				ACT_DELETE: cnt_q <= cnt_q - CNT_W'(1);
				default:    cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_action;
			pos_q <= in_position;
			val_q <= in_value;
		end
		if (cmd.check) begin
			stat_q <= err_code;
		end
		if (cmd.init) begin
			idx_q <= (act_q == ACT_INSERT) ? cnt_q : CNT_W'(pm1);
		end else if (cmd.shift_wr) begin
			idx_q <= (act_q == ACT_INSERT) ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
		end
		if (cmd.load_res) begin
			res_status_q <= stat_q;
			res_rdata_q  <= (act_q == ACT_READ && stat_q == ST_OK) ? ram_rdata : '0;
			res_count_q  <= cnt_q;
		end
	end

	assign res_status     = res_status_q;
	assign res_read_value = res_rdata_q;
	assign res_count      = res_count_q;

endmodule

[rtl/olid_ctrl.sv]
`timescale 1ns / 1ps

module olid_ctrl import olid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  olid_sts_t sts,
	output olid_cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_SHIFT_RD = 3'd2;
	localparam logic [2:0] S_SHIFT_WR = 3'd3;
	localparam logic [2:0] S_COMMIT   = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.err) begin
					state_d = S_DONE;
				end else begin
					case (sts.action)
						ACT_APPEND: state_d = S_COMMIT;
						ACT_READ: begin
							cmd.rd  = 1'b1;
							state_d = S_DONE;
						end
						default: begin
							cmd.init = 1'b1;
							state_d  = S_SHIFT_RD;
						end
					endcase
				end
			end
			S_SHIFT_RD: begin
				if (sts.more) begin
					cmd.rd  = 1'b1;
					state_d = S_SHIFT_WR;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_res = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/ordered_list_insert_delete.sv]
`timescale 1ns / 1ps
// An item is accepted in the idle state, then passes the check state; an insert or delete
// that passes the check runs the shift loop, a read and a write state per entry moved, and
// any change that passes it then runs the commit state; the done state registers the result
// once the result register is free. One item at a time: the next item is accepted only after
// the last result is registered. The shift runs through the single list RAM's two ports.
// Reset: arst_n clears the entry count, the controller state and the result valid flag.

module ordered_list_insert_delete import olid_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	olid_req_if.sink   req,
	olid_res_if.source res
);

	// The controller sequences each item: check, optional shift loop and commit for a change, result.
	// The datapath holds the captured item, the entry count, the shift index and the
	// list RAM, and the result register that lets a new item start while a result waits.
	olid_cmd_t cmd;
	olid_sts_t sts;

	olid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	olid_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_action     (req.action),
		.in_position   (req.position),
		.in_value      (req.value),
		.res_status    (res.status),
		.res_read_value(res.read_value),
		.res_count     (res.count)
	);

endmodule

[verif/ordered_list_insert_delete_tb.sv]
`timescale 1ns / 1ps

module ordered_list_insert_delete_tb;
	import olid_pkg::*;

	// Extremes of the signed value field.
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

	// Cycles to wait after the last result, sized for an item that moves at most
	// DEPTH entries on top of the other states that every item passes through.
	localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

	// Length and spacing of the long receiver hold-offs.
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_EVERY  = 900;

	// One list operation as the sender offers it, with its own idle gap and a
	// flag that makes the sender wait for every outstanding result first.
	typedef struct {
		logic [ACT_W-1:0]        action;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
		int unsigned             gap;
		bit                      drain;
	} list_op_t;

	// The answer that the block gives for one operation.
	typedef struct {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0]        count;
	} list_result_t;

	// Mix of operations for one phase of the random part.
	typedef enum {MIX_GROW, MIX_EVEN, MIX_SHRINK} op_mix_t;

	logic clk = 1'b0;
	logic arst_n;

	olid_req_if req_ch();
	olid_res_if res_ch();

	ordered_list_insert_delete uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	// Operations waiting to be offered, and the answers still owed by the block.
	list_op_t     op_queue[$];
	list_result_t owed_results[$];

	// Our own copy of the list, updated as each operation is accepted.
	logic signed [VAL_W-1:0] list_vals [DEPTH];
	int                      list_len = 0;

	// Length of the list as the stimulus generator expects it to be. It lets
	// the generator pick positions that are mostly valid.
	int gen_len = 0;
	bit quiet_sender = 1'b0;
	bit drain_next = 1'b0;
	int op_total = 0;

	// Handshake bookkeeping, sampled at the rising edge.
	bit req_fire = 1'b0;
	bit res_fire = 1'b0;
	int items_accepted = 0;
	int results_seen = 0;
	int fail_count = 0;

	int sender_wait = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int hold_at = 400;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one operation to our copy of the list and works out the answer.
	// A failed operation leaves the list as it was. The position check of an
	// insert comes before the full check, so a full list with a bad position
	// reports the bad position.
	task automatic list_apply(input list_op_t op, output list_result_t r);
		int p;
		int k;
		p = int'(op.position);
		r.status = ST_OK;
		r.read_value = '0;
		case (op.action)
			ACT_APPEND: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_vals[ADDR_W'(list_len)] = op.value;
					list_len++;
				end
			end
			ACT_INSERT: begin
				if (p < 1 || p > list_len + 1) begin
					r.status = ST_BADPOS;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = list_len; k > p - 1; k--)
						list_vals[ADDR_W'(k)] = list_vals[ADDR_W'(k-1)];
					list_vals[ADDR_W'(p-1)] = op.value;
					list_len++;
				end
			end
			ACT_DELETE: begin
				if (p < 1 || p > list_len) begin
					r.status = ST_BADPOS;
				end else begin
					for (k = p - 1; k < list_len - 1; k++)
						list_vals[ADDR_W'(k)] = list_vals[ADDR_W'(k+1)];
					list_len--;
				end
			end
			default: begin
				if (p < 1 || p > list_len)
					r.status = ST_BADPOS;
				else
					r.read_value = list_vals[ADDR_W'(p-1)];
			end
		endcase
		r.count = list_len[CNT_W-1:0];
	endtask

	// Queues one operation and tracks the list length it should leave behind.
	task automatic add_op(input logic [ACT_W-1:0] act, input int pos,
			input logic signed [VAL_W-1:0] val);
		list_op_t op;
		op.action = act;
		op.position = pos[POS_W-1:0];
		op.value = val;
		op.gap = quiet_sender ? 0 : $urandom_range(0, 5);
		op.drain = drain_next;
		drain_next = 1'b0;
		case (act)
			ACT_APPEND: begin
				if (gen_len < DEPTH)
					gen_len++;
			end
			ACT_INSERT: begin
				if (pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH)
					gen_len++;
			end
			ACT_DELETE: begin
				if (pos >= 1 && pos <= gen_len)
					gen_len--;
			end
			default: ;
		endcase
		op_queue.push_back(op);
	endtask

	// Random value with the extremes, zero and minus one drawn more often.
	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 11))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// A position in 1..hi, landing on either end more often than a flat draw.
	function automatic int pick_position(input int hi);
		case ($urandom_range(0, 4))
			0: return 1;
			1: return hi;
			default: return $urandom_range(1, hi);
		endcase
	endfunction

	// One random operation. Most are well formed for the current length, so
	// the list really grows, shrinks and fills up; a small share is noise with
	// any action and any position.
	task automatic add_random_op(input op_mix_t mix);
		int r;
		int w_app;
		int w_ins;
		int w_del;
		int pos;
		logic [ACT_W-1:0] act;
		case (mix)
			MIX_GROW: begin
				w_app = 35; w_ins = 35; w_del = 10;
			end
			MIX_SHRINK: begin
				w_app = 10; w_ins = 10; w_del = 50;
			end
			default: begin
				w_app = 20; w_ins = 30; w_del = 25;
			end
		endcase
		if ($urandom_range(0, 99) < 8) begin
			add_op(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 127), rand_value());
		end else begin
			r = $urandom_range(0, 99);
			if (r < w_app)
				act = ACT_APPEND;
			else if (r < w_app + w_ins)
				act = ACT_INSERT;
			else if (r < w_app + w_ins + w_del)
				act = ACT_DELETE;
			else
				act = ACT_READ;
			case (act)
				ACT_APPEND: pos = $urandom_range(0, 127);
				ACT_INSERT: pos = pick_position(gen_len + 1);
				default: pos = (gen_len == 0) ? $urandom_range(0, 1) : pick_position(gen_len);
			endcase
			add_op(act, pos, rand_value());
		end
	endtask

	// Stimulus, reset and the end of the run. The whole sequence of operations
	// is built before reset is released; the driver then plays it out.
	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = ACT_APPEND;
		req_ch.position = '0;
		req_ch.value = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;

		// Directed part: an empty list first, then edges of the position range
		// for every action, with the extreme values stored and read back.
		add_op(ACT_READ, 1, '0);          // read from an empty list
		add_op(ACT_DELETE, 1, '0);        // delete from an empty list
		add_op(ACT_INSERT, 0, 32'sd5);    // position zero is never valid for an insert
		add_op(ACT_INSERT, 2, 32'sd6);    // beyond count plus one
		add_op(ACT_INSERT, 1, VAL_MIN);   // insert into an empty list
		add_op(ACT_APPEND, 0, VAL_MAX);
		add_op(ACT_INSERT, 1, 32'sd7);    // at the head, everything moves up
		add_op(ACT_INSERT, 4, '1);        // at count plus one, the tail
		add_op(ACT_INSERT, 2, '0);        // in the middle
		add_op(ACT_READ, 0, '0);
		add_op(ACT_READ, 1, '0);
		add_op(ACT_READ, 5, '0);          // the last entry
		add_op(ACT_READ, 6, '0);          // one past the last entry
		add_op(ACT_READ, 127, '0);
		add_op(ACT_DELETE, 0, '0);
		add_op(ACT_DELETE, 6, '0);
		add_op(ACT_DELETE, 5, '0);        // the last entry, nothing moves
		add_op(ACT_DELETE, 1, '0);        // the first entry, everything moves down
		add_op(ACT_APPEND, 127, 32'sh5A5A_5A5A); // position is ignored by append
		add_op(ACT_INSERT, 2, 32'shA5A5_A5A5);
		add_op(ACT_READ, 2, '0);
		add_op(ACT_DELETE, 2, '0);
		add_op(ACT_READ, 4, '0);

		// Fill the list to the top without gaps, then work its full cases.
		drain_next = 1'b1;
		quiet_sender = 1'b1;
		while (gen_len < DEPTH)
			add_op(ACT_APPEND, $urandom_range(0, 127), rand_value());
		quiet_sender = 1'b0;
		add_op(ACT_APPEND, 0, rand_value());        // append when full
		add_op(ACT_INSERT, DEPTH + 1, rand_value()); // valid position, full list
		add_op(ACT_INSERT, 1, rand_value());         // valid position, full list
		add_op(ACT_INSERT, DEPTH + 2, rand_value()); // bad position wins over full
		add_op(ACT_INSERT, 0, rand_value());
		add_op(ACT_READ, DEPTH, '0);
		add_op(ACT_READ, DEPTH + 1, '0);
		add_op(ACT_DELETE, DEPTH, '0);
		add_op(ACT_DELETE, 1, '0);                   // longest move down
		add_op(ACT_INSERT, 1, rand_value());         // longest move up
		add_op(ACT_APPEND, 0, rand_value());
		add_op(ACT_READ, 1, '0);

		// Random part in phases that grow, mix and shrink the list, so that it
		// keeps passing through both the empty and the full state. Some phases
		// have no sender gaps, and now and then the sender waits for the block
		// to drain completely.
		for (int i = 0; i < 1760; i++) begin
			quiet_sender = ((i / 200) % 4) == 1;
			if (i % 300 == 150)
				drain_next = 1'b1;
			case ((i / 120) % 4)
				0: add_random_op(MIX_GROW);
				2: add_random_op(MIX_SHRINK);
				default: add_random_op(MIX_EVEN);
			endcase
		end
		op_total = op_queue.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Every operation gives exactly one result.
		wait (items_accepted == op_total && results_seen >= op_total);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#12_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Sender. A new item is put up only once the previous one has been taken;
	// until then valid and the payload hold steady.
	always @(negedge clk) begin
		list_op_t op;
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (op_queue.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (op_queue[0].drain && owed_results.size() != 0) begin
				req_ch.valid <= 1'b0;
			end else if (sender_wait < op_queue[0].gap) begin
				sender_wait++;
				req_ch.valid <= 1'b0;
			end else begin
				op = op_queue.pop_front();
				sender_wait = 0;
				req_ch.valid <= 1'b1;
				req_ch.action <= op.action;
				req_ch.position <= op.position;
				req_ch.value <= op.value;
			end
		end
	end

	// Receiver. It stalls for a random number of cycles after each result,
	// except in stretches where it always takes results at once, and it stays
	// off entirely while a long hold-off is running.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire)
				recv_stall = (((results_seen / 250) % 3) == 2) ? 0 : $urandom_range(0, 5);
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Long hold-offs on the result side. The sender keeps offering items, so
	// the block ends up holding a finished result and refusing new input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (results_seen >= hold_at) begin
				hold_left <= HOLD_CYCLES;
				hold_at <= hold_at + HOLD_EVERY;
			end
		end
	end

	// Monitor. Results are checked in order against the oldest owed answer,
	// and each accepted operation is applied to our copy of the list.
	always @(posedge clk) begin
		list_op_t     op;
		list_result_t want;
		list_result_t got;
		if (arst_n) begin
			req_fire <= req_ch.valid && req_ch.ready;
			res_fire <= res_ch.valid && res_ch.ready;

			if (res_ch.valid && res_ch.ready) begin
				results_seen <= results_seen + 1;
				if (owed_results.size() == 0) begin
					$error("result arrived with no operation outstanding");
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					got.status = res_ch.status;
					got.read_value = res_ch.read_value;
					got.count = res_ch.count;
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							want.read_value, got.read_value);
						fail_count++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got.count);
						fail_count++;
					end
				end
			end

			if (req_ch.valid && req_ch.ready) begin
				items_accepted <= items_accepted + 1;
				op.action = req_ch.action;
				op.position = req_ch.position;
				op.value = req_ch.value;
				op.gap = 0;
				op.drain = 1'b0;
				list_apply(op, want);
				owed_results.push_back(want);
			end
		end
	end

endmodule
